@@ src/secd_pkg.sv @@
// Shared types and constants for the speech end silence detector.
// Holds the configuration and recording state structs, stop reason codes
// and register indexes. No dependencies.
package secd_pkg;

	// Field widths fixed by the sample and WAV size formats
	localparam int SAMPLE_W   = 16;
	localparam int THRESH_W   = 16;
	localparam int CHUNK_W    = 12;
	localparam int STOP_W     = 10;
	localparam int COUNT_W    = 17;
	localparam int BYTES_W    = 18;
	localparam int RIFF_W     = 19;
	localparam int REASON_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LENGTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_SAMPLES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PREROLL_COUNT     = 3'd4;

	// Register reset values
	localparam logic [THRESH_W-1:0] RST_SILENCE_THRESHOLD = 16'd0;
	localparam logic [CHUNK_W-1:0]  RST_CHUNK_LENGTH      = 12'd150;
	localparam logic [STOP_W-1:0]   RST_QUIET_LIMIT       = 10'd160;
	localparam logic [COUNT_W-1:0]  RST_CAPACITY_SAMPLES  = 17'd96000;
	localparam logic [COUNT_W-1:0]  RST_PREROLL_COUNT     = 17'd0;

	// Stop reason codes
	localparam logic [REASON_W-1:0] REASON_NONE    = 2'd0;
	localparam logic [REASON_W-1:0] REASON_SILENCE = 2'd1;
	localparam logic [REASON_W-1:0] REASON_FULL    = 2'd2;

	// RIFF size is data bytes plus the rest of the 44-byte header
	localparam logic [RIFF_W-1:0] RIFF_OFFSET = 19'd36;

	typedef struct packed {
		logic [THRESH_W-1:0] threshold;
		logic [CHUNK_W-1:0]  chunk_len;
		logic [STOP_W-1:0]   quiet_limit;
		logic [COUNT_W-1:0]  capacity;
		logic [COUNT_W-1:0]  preroll;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  total;
		logic [CHUNK_W-1:0]  pos;
		logic [SAMPLE_W-1:0] peak;
		logic                voice;
		logic [STOP_W-1:0]   run;
		logic [REASON_W-1:0] reason;
	} rec_state_t;

endpackage

@@ src/secd_if.sv @@
// Handshake channel interfaces for the detector: sample input and result output.
// Depends on secd_pkg for field widths.
interface secd_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [secd_pkg::SAMPLE_W-1:0] sample;
	logic                                 start_req;

	modport source (output valid, output sample, output start_req, input ready);
	modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface secd_result_if;
	logic                              valid;
	logic                              ready;
	logic                              done_res;
	logic [secd_pkg::REASON_W-1:0]     stop_reason;
	logic [secd_pkg::COUNT_W-1:0]      total_samples;
	logic [secd_pkg::BYTES_W-1:0]      data_bytes;
	logic [secd_pkg::RIFF_W-1:0]       riff_size;

	modport source (output valid, output done_res, output stop_reason, output total_samples,
		output data_bytes, output riff_size, input ready);
	modport sink (input valid, input done_res, input stop_reason, input total_samples,
		input data_bytes, input riff_size, output ready);
endinterface

@@ src/secd_cfg_regs.sv @@
// Configuration register bank of the detector, written through a plain write port.
// Depends on secd_pkg for the cfg_t struct, indexes and reset values.
module secd_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [secd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [secd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output secd_pkg::cfg_t                      cfg
);

	secd_pkg::cfg_t cfg_q;

	// Decode the index and keep the low bits of the write data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= secd_pkg::RST_SILENCE_THRESHOLD;
			cfg_q.chunk_len   <= secd_pkg::RST_CHUNK_LENGTH;
			cfg_q.quiet_limit <= secd_pkg::RST_QUIET_LIMIT;
			cfg_q.capacity    <= secd_pkg::RST_CAPACITY_SAMPLES;
			cfg_q.preroll     <= secd_pkg::RST_PREROLL_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				secd_pkg::REG_SILENCE_THRESHOLD: begin
					cfg_q.threshold <= cfg_wdata[secd_pkg::THRESH_W-1:0];
				end
				secd_pkg::REG_CHUNK_LENGTH: begin
					cfg_q.chunk_len <= cfg_wdata[secd_pkg::CHUNK_W-1:0];
				end
				secd_pkg::REG_QUIET_LIMIT: begin
					cfg_q.quiet_limit <= cfg_wdata[secd_pkg::STOP_W-1:0];
				end
				secd_pkg::REG_CAPACITY_SAMPLES: begin
					cfg_q.capacity <= cfg_wdata[secd_pkg::COUNT_W-1:0];
				end
				secd_pkg::REG_PREROLL_COUNT: begin
					cfg_q.preroll <= cfg_wdata[secd_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/secd_step.sv @@
// Per-sample update of the recording state: peak tracking, chunk judging,
// quiet run counting and buffer room checks. Depends on secd_pkg.
module secd_step (
	input  secd_pkg::cfg_t                      cfg,
	input  secd_pkg::rec_state_t                cur,
	input  logic [secd_pkg::SAMPLE_W-1:0]       sample,
	input  logic                                start_req,
	output secd_pkg::rec_state_t                nxt
);

	logic [secd_pkg::CHUNK_W-1:0]  len;
	logic [secd_pkg::COUNT_W-1:0]  pre;
	logic [secd_pkg::SAMPLE_W-1:0] mag;
	logic [secd_pkg::COUNT_W-1:0]  total_inc;
	logic [secd_pkg::CHUNK_W-1:0]  pos_inc;
	logic [secd_pkg::SAMPLE_W-1:0] peak_new;
	logic [secd_pkg::STOP_W-1:0]   run_inc;
	logic                          over_start;
	logic                          over_end;
	secd_pkg::rec_state_t          base;

	// Zero chunk length acts as one; preroll clamps to capacity
	assign len = (cfg.chunk_len == '0) ? secd_pkg::CHUNK_W'(1) : cfg.chunk_len;
	assign pre = (cfg.preroll > cfg.capacity) ? cfg.capacity : cfg.preroll;

	// Magnitude; full-scale negative wraps to 0x8000, which is right
	assign mag = sample[secd_pkg::SAMPLE_W-1] ? secd_pkg::SAMPLE_W'(~sample + 1'b1) : sample;

	// Restart the recording on a start request
	always_comb begin
		base = cur;
		if (start_req) begin
			base.total  = pre;
			base.pos    = '0;
			base.peak   = '0;
			base.voice  = (pre != '0);
			base.run    = '0;
			base.reason = secd_pkg::REASON_NONE;
		end
	end

	assign total_inc = base.total + 1'b1;
	assign pos_inc   = base.pos + 1'b1;
	assign peak_new  = (mag > base.peak) ? mag : base.peak;
	assign run_inc   = (base.run != '1) ? base.run + 1'b1 : base.run;

	// Room checks: would a whole chunk still fit
	assign over_start = ({1'b0, base.total} + {{(secd_pkg::COUNT_W + 1 - secd_pkg::CHUNK_W){1'b0}},
		len}) > {1'b0, cfg.capacity};
	assign over_end = ({1'b0, total_inc} + {{(secd_pkg::COUNT_W + 1 - secd_pkg::CHUNK_W){1'b0}},
		len}) > {1'b0, cfg.capacity};

	// Count the sample, judge the chunk at its end
	always_comb begin
		nxt = base;
		if (base.reason == secd_pkg::REASON_NONE && base.pos == '0 && over_start) begin
			nxt.reason = secd_pkg::REASON_FULL;
		end
		if (nxt.reason == secd_pkg::REASON_NONE) begin
			nxt.total = total_inc;
			nxt.peak  = peak_new;
			nxt.pos   = pos_inc;
			if (pos_inc >= len) begin
				if (cfg.threshold != '0) begin
					if (peak_new >= cfg.threshold) begin
						nxt.voice = 1'b1;
						nxt.run   = '0;
					end else if (base.voice) begin
						nxt.run = run_inc;
						if (run_inc >= cfg.quiet_limit) begin
							nxt.reason = secd_pkg::REASON_SILENCE;
						end
					end
				end
				nxt.pos  = '0;
				nxt.peak = '0;
				if (nxt.reason == secd_pkg::REASON_NONE && over_end) begin
					nxt.reason = secd_pkg::REASON_FULL;
				end
			end
		end
	end

endmodule

@@ src/speech_end_silence_detector_unit.sv @@
// Top level of the speech end silence detector.
// Uses secd_pkg, secd_if, secd_cfg_regs and secd_step.
//
// Usage:
//   sample_ch carries one signed 16-bit PCM sample per item, with start_req
//   marking the first sample of a new recording. result_ch returns exactly one
//   item per sample: done flag, stop reason, running sample count, WAV data
//   byte count and RIFF size. Registers are written through cfg_we, cfg_index
//   and cfg_wdata while no item is in flight.
//   Each sample is held in the input register and its result in the result
//   register, which drives result_ch.
//   Throughput: one sample per cycle unless result_ch stalls; secd_step does
//   one compare and increment pass between input and result registers.
//   Reset: registers take their defaults and recording state clears (count
//   zero, no voice seen, still recording); both channels come up empty.
//   Stall: while result_ch is held, the pending result stays stable and one
//   more sample is taken into the input register; sample_ch then drops ready.
//   After the recording ends, samples without start_req still give a result
//   that repeats the final counts.
module speech_end_silence_detector_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [secd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [secd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	secd_sample_if.sink                         sample_ch,
	secd_result_if.source                       result_ch
);

	secd_pkg::cfg_t                cfg;
	secd_pkg::rec_state_t          state_q;
	secd_pkg::rec_state_t          state_nxt;
	logic                          valid_s1;
	logic [secd_pkg::SAMPLE_W-1:0] sample_s1;
	logic                          start_s1;
	logic                          out_valid_q;
	logic [secd_pkg::BYTES_W-1:0]  data_bytes_q;
	logic [secd_pkg::RIFF_W-1:0]   riff_size_q;
	logic [secd_pkg::BYTES_W-1:0]  data_bytes_nxt;
	logic                          advance;

	secd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	secd_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.sample    (sample_s1),
		.start_req (start_s1),
		.nxt       (state_nxt)
	);

	// Move the registered item into the result slot when it is free
	assign advance         = valid_s1 && (!out_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			sample_s1 <= sample_ch.sample;
			start_s1  <= sample_ch.start_req;
		end
	end

	// Recording state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.total  <= '0;
			state_q.pos    <= '0;
			state_q.peak   <= '0;
			state_q.voice  <= 1'b0;
			state_q.run    <= '0;
			state_q.reason <= secd_pkg::REASON_NONE;
			out_valid_q    <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// WAV sizes derived from the new count
	assign data_bytes_nxt = {state_nxt.total, 1'b0};

	always_ff @(posedge clk) begin
		if (advance) begin
			data_bytes_q <= data_bytes_nxt;
			riff_size_q  <= {1'b0, data_bytes_nxt} + secd_pkg::RIFF_OFFSET;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.done_res      = (state_q.reason != secd_pkg::REASON_NONE);
	assign result_ch.stop_reason   = state_q.reason;
	assign result_ch.total_samples = state_q.total;
	assign result_ch.data_bytes    = data_bytes_q;
	assign result_ch.riff_size     = riff_size_q;

endmodule

@@ src/secd_checker.sv @@
// Port-level checks for the detector, bound to the top level.
// Depends on secd_pkg for widths, reason codes and the RIFF offset.
module secd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              res_valid,
	input  logic                              res_ready,
	input  logic                              done_res,
	input  logic [secd_pkg::REASON_W-1:0]     stop_reason,
	input  logic [secd_pkg::COUNT_W-1:0]      total_samples,
	input  logic [secd_pkg::BYTES_W-1:0]      data_bytes,
	input  logic [secd_pkg::RIFF_W-1:0]       riff_size
);

	// Result channel is empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	// A stalled result stays valid and keeps its sample count, stop reason and RIFF size
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(total_samples)
			&& $stable(stop_reason) && $stable(riff_size))
		else $error("stalled result changed");

	// Done flag agrees with the stop reason
	a_done_reason: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> done_res == (stop_reason != secd_pkg::REASON_NONE))
		else $error("done flag and stop reason disagree");

	// WAV sizes follow from the sample count
	a_wav_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> data_bytes == {total_samples, 1'b0}
			&& riff_size == {1'b0, data_bytes} + secd_pkg::RIFF_OFFSET)
		else $error("WAV size fields inconsistent");

endmodule

bind speech_end_silence_detector_unit secd_checker u_secd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result_ch.valid),
	.res_ready     (result_ch.ready),
	.done_res      (result_ch.done_res),
	.stop_reason   (result_ch.stop_reason),
	.total_samples (result_ch.total_samples),
	.data_bytes    (result_ch.data_bytes),
	.riff_size     (result_ch.riff_size)
);
